FILE: hdl/dispenser_alarm_controller_top_macros.svh
// Assertion macros for the dispenser alarm controller.
// Each macro expands to a labeled concurrent assertion in simulation and
// to nothing in synthesis.
`ifndef DISPENSER_ALARM_CONTROLLER_TOP_MACROS_SVH
`define DISPENSER_ALARM_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define DAC_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define DAC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define DAC_ASSERT_SAME(name, clk, rst, ante, cons, msg)

`define DAC_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hdl/dac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dac_pkg;

   // Sample widths of the sensor inputs
   localparam int JOY_BITS  = 12;
   localparam int DIST_BITS = 16;

   // Register widths
   localparam int JOY_REG_BITS  = 12;
   localparam int DIST_REG_BITS = 16;
   localparam int PWM_BITS      = 12;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_IDX_BITS  = 3;

   // Compare widths: wide enough for both the sample and the register
   localparam int JOY_CMP_BITS  = (JOY_BITS > JOY_REG_BITS) ? JOY_BITS : JOY_REG_BITS;
   localparam int DIST_CMP_BITS = (DIST_BITS > DIST_REG_BITS) ? DIST_BITS : DIST_REG_BITS;

   // Request tdata layout, lowest bit first
   localparam int REQ_SYNC_LSB   = 0;
   localparam int REQ_CVALID_LSB = 1;
   localparam int REQ_HOUR_LSB   = 2;
   localparam int REQ_MINUTE_LSB = 7;
   localparam int REQ_PRESS_LSB  = 13;
   localparam int REQ_JOY_LSB    = 14;
   localparam int REQ_DVALID_LSB = REQ_JOY_LSB + JOY_BITS;
   localparam int REQ_DIST_LSB   = REQ_DVALID_LSB + 1;
   localparam int REQ_LIGHT_LSB  = REQ_DIST_LSB + DIST_BITS;
   localparam int REQ_FIELD_BITS = REQ_LIGHT_LSB + 1;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;

   // Response tdata layout, lowest bit first
   localparam int RSP_FIELD_BITS = 3 + 5 + 6 + PWM_BITS + PWM_BITS + 2 + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_FIELD_BITS;

   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [5:0] MINUTE_MAX = 6'd59;

   // Register reset values
   localparam logic [JOY_REG_BITS-1:0]  JOY_UP_RESET     = 12'd4090;
   localparam logic [JOY_REG_BITS-1:0]  JOY_DOWN_RESET   = 12'd25;
   localparam logic [DIST_REG_BITS-1:0] NEAR_DIST_RESET  = 16'd400;
   localparam logic [DIST_REG_BITS-1:0] MAX_DIST_RESET   = 16'd4000;
   // 550 + 100 * 1950 / 180, truncated
   localparam logic [PWM_BITS-1:0]      SERVO_OPEN_RESET = 12'd1633;
   localparam logic [PWM_BITS-1:0]      SERVO_SHUT_RESET = 12'd550;
   localparam logic [PWM_BITS-1:0]      BUZZER_RESET     = 12'd2048;

   typedef enum logic [2:0] {
      MODE_INITIAL     = 3'd0,
      MODE_SHOW        = 3'd1,
      MODE_ASK         = 3'd2,
      MODE_SET_HOURS   = 3'd3,
      MODE_SET_MINUTES = 3'd4,
      MODE_ARMED       = 3'd5,
      MODE_TRIGGERED   = 3'd6,
      MODE_MONITOR     = 3'd7
   } mode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_JOY_UP      = 3'd0,
      CSR_JOY_DOWN    = 3'd1,
      CSR_NEAR_DIST   = 3'd2,
      CSR_MAX_DIST    = 3'd3,
      CSR_SERVO_OPEN  = 3'd4,
      CSR_SERVO_SHUT  = 3'd5,
      CSR_BUZZER_DUTY = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      PILL_OFF       = 2'd0,
      PILL_NOT_TAKEN = 2'd1,
      PILL_TAKEN     = 2'd2
   } pill_type;

endpackage

`default_nettype wire

FILE: hdl/dispenser_alarm_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                Payload
// req_      in         req_tvalid / req_tready  one sensor tick (req_tdata)
// rsp_      out        rsp_tvalid / rsp_tready  one status result (rsp_tdata)
// csr_      in         csr_valid / csr_ready    register index + write data
//
// One result per tick, registered in the cycle after the request transaction.
// A new tick is taken every cycle while the response register is empty or
// being drained in the same cycle, so the sustained rate is one per clock.
// Stalls on rsp_ hold the response register and deassert req_tready.
// Synchronous active-high reset clears the mode, alarm and actuator state
// and loads the register defaults; csr_ready is always high.

`include "dispenser_alarm_controller_top_macros.svh"

module dispenser_alarm_controller_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request: time_sync, clock_valid, clock_hour, clock_minute, button_press,
   // joystick_y, distance_valid, distance_mm, light_level, zero fill
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [dac_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // Response: mode, alarm_hour_out, alarm_minute_out, buzzer_level,
   // servo_pulse, pill_status, distance_error, zero fill
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [dac_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   // Register writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [dac_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [dac_pkg::CSR_DATA_BITS-1:0] csr_data
);

   // Configuration registers
   logic [dac_pkg::JOY_REG_BITS-1:0]  joy_up_ff;
   logic [dac_pkg::JOY_REG_BITS-1:0]  joy_down_ff;
   logic [dac_pkg::DIST_REG_BITS-1:0] near_dist_ff;
   logic [dac_pkg::DIST_REG_BITS-1:0] max_dist_ff;
   logic [dac_pkg::PWM_BITS-1:0]      servo_open_pulse_ff;
   logic [dac_pkg::PWM_BITS-1:0]      servo_shut_pulse_ff;
   logic [dac_pkg::PWM_BITS-1:0]      buzzer_duty_ff;

   // Controller state
   dac_pkg::mode_type mode_ff, mode_in;
   logic [4:0]        alarm_hour_ff, alarm_hour_in;
   logic [5:0]        alarm_minute_ff, alarm_minute_in;
   logic              alarm_armed_ff, alarm_armed_in;
   logic              servo_open_ff, servo_open_in;
   logic              buzzer_on_ff, buzzer_on_in;
   logic              sensing_ff, sensing_in;

   // Response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [dac_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // Unpacked request fields
   logic                          time_sync;
   logic                          clock_valid;
   logic [4:0]                    clock_hour;
   logic [5:0]                    clock_minute;
   logic                          button_press;
   logic [dac_pkg::JOY_BITS-1:0]  joystick_y;
   logic                          distance_valid;
   logic [dac_pkg::DIST_BITS-1:0] distance_mm;
   logic                          light_level;

   logic                              req_fire;
   logic                              joy_up;
   logic                              joy_down;
   logic [dac_pkg::DIST_CMP_BITS-1:0] dist_ext;
   logic                              dist_ok;
   logic                              dist_near;
   logic                              alarm_hit;
   logic                              dist_err;
   logic [dac_pkg::PWM_BITS-1:0]      buzzer_level;
   logic [dac_pkg::PWM_BITS-1:0]      servo_pulse;
   dac_pkg::pill_type                 pill_status;

   // Wrapping up/down step; a value above top is pulled back into range
   function automatic logic [5:0] joy_step(input logic up, input logic down,
                                           input logic [5:0] value,
                                           input logic [5:0] top);
      logic [5:0] result;
      result = value;
      if (up) begin
         result = (value >= top) ? 6'd0 : value + 6'd1;
      end else if (down) begin
         result = (value == 6'd0 || value > top) ? top : value - 6'd1;
      end
      return result;
   endfunction

   assign time_sync      = req_tdata[dac_pkg::REQ_SYNC_LSB];
   assign clock_valid    = req_tdata[dac_pkg::REQ_CVALID_LSB];
   assign clock_hour     = req_tdata[dac_pkg::REQ_HOUR_LSB +: 5];
   assign clock_minute   = req_tdata[dac_pkg::REQ_MINUTE_LSB +: 6];
   assign button_press   = req_tdata[dac_pkg::REQ_PRESS_LSB];
   assign joystick_y     = req_tdata[dac_pkg::REQ_JOY_LSB +: dac_pkg::JOY_BITS];
   assign distance_valid = req_tdata[dac_pkg::REQ_DVALID_LSB];
   assign distance_mm    = req_tdata[dac_pkg::REQ_DIST_LSB +: dac_pkg::DIST_BITS];
   assign light_level    = req_tdata[dac_pkg::REQ_LIGHT_LSB];

   // Response register frees up when it is empty or drained this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Joystick thresholds; up wins when both match
   assign joy_up   = dac_pkg::JOY_CMP_BITS'(joystick_y) >= dac_pkg::JOY_CMP_BITS'(joy_up_ff);
   assign joy_down = dac_pkg::JOY_CMP_BITS'(joystick_y) <= dac_pkg::JOY_CMP_BITS'(joy_down_ff);

   // Distance qualification: valid, nonzero and not beyond the max range
   assign dist_ext  = dac_pkg::DIST_CMP_BITS'(distance_mm);
   assign dist_ok   = distance_valid && (distance_mm != '0)
                      && (dist_ext <= dac_pkg::DIST_CMP_BITS'(max_dist_ff));
   assign dist_near = dist_ext <= dac_pkg::DIST_CMP_BITS'(near_dist_ff);

   assign alarm_hit = alarm_armed_ff && clock_valid && (clock_hour == alarm_hour_ff)
                      && (clock_minute == alarm_minute_ff);

   // Mode update for one tick. Sync beats the alarm, and either event
   // suppresses the mode action for this tick.
   always_comb begin
      mode_in         = mode_ff;
      alarm_hour_in   = alarm_hour_ff;
      alarm_minute_in = alarm_minute_ff;
      alarm_armed_in  = alarm_armed_ff;
      servo_open_in   = servo_open_ff;
      buzzer_on_in    = buzzer_on_ff;
      sensing_in      = sensing_ff;
      dist_err        = 1'b0;
      if (time_sync) begin
         mode_in = dac_pkg::MODE_SHOW;
      end else if (alarm_hit) begin
         mode_in        = dac_pkg::MODE_TRIGGERED;
         alarm_armed_in = 1'b0;
      end else begin
         unique case (mode_ff)
            dac_pkg::MODE_INITIAL: begin
            end
            dac_pkg::MODE_SHOW: begin
               mode_in = dac_pkg::MODE_ASK;
            end
            dac_pkg::MODE_ASK: begin
               if (button_press) begin
                  // capture the clock only when it is valid and in range
                  if (clock_valid && clock_hour <= dac_pkg::HOUR_MAX
                      && clock_minute <= dac_pkg::MINUTE_MAX) begin
                     alarm_hour_in   = clock_hour;
                     alarm_minute_in = clock_minute;
                  end else begin
                     alarm_hour_in   = '0;
                     alarm_minute_in = '0;
                  end
                  mode_in = dac_pkg::MODE_SET_HOURS;
               end
            end
            dac_pkg::MODE_SET_HOURS: begin
               alarm_hour_in = 5'(joy_step(joy_up, joy_down, {1'b0, alarm_hour_ff},
                                           {1'b0, dac_pkg::HOUR_MAX}));
               if (button_press) begin
                  mode_in = dac_pkg::MODE_SET_MINUTES;
               end
            end
            dac_pkg::MODE_SET_MINUTES: begin
               alarm_minute_in = joy_step(joy_up, joy_down, alarm_minute_ff,
                                          dac_pkg::MINUTE_MAX);
               if (button_press) begin
                  mode_in        = dac_pkg::MODE_ARMED;
                  alarm_armed_in = 1'b1;
               end
            end
            dac_pkg::MODE_ARMED: begin
            end
            dac_pkg::MODE_TRIGGERED: begin
               buzzer_on_in = 1'b1;
               mode_in      = dac_pkg::MODE_MONITOR;
            end
            dac_pkg::MODE_MONITOR: begin
               if (dist_ok) begin
                  if (dist_near) begin
                     if (!servo_open_ff) begin
                        servo_open_in = 1'b1;
                        buzzer_on_in  = 1'b0;
                        sensing_in    = 1'b1;
                     end
                  end else if (servo_open_ff) begin
                     // dispenser closed: back to armed, alarm stays disarmed
                     servo_open_in = 1'b0;
                     sensing_in    = 1'b0;
                     mode_in       = dac_pkg::MODE_ARMED;
                  end
               end else begin
                  dist_err = 1'b1;
               end
            end
         endcase
      end
   end

   // Result fields from the updated state
   assign buzzer_level = buzzer_on_in ? buzzer_duty_ff : '0;
   assign servo_pulse  = servo_open_in ? servo_open_pulse_ff : servo_shut_pulse_ff;
   always_comb begin
      if (!sensing_in) begin
         pill_status = dac_pkg::PILL_OFF;
      end else if (light_level) begin
         pill_status = dac_pkg::PILL_NOT_TAKEN;
      end else begin
         pill_status = dac_pkg::PILL_TAKEN;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{dac_pkg::RSP_PAD_BITS{1'b0}}, dist_err, pill_status,
                         servo_pulse, buzzer_level, alarm_minute_in,
                         alarm_hour_in, mode_in};
      end
   end

   // Configuration writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         joy_up_ff           <= dac_pkg::JOY_UP_RESET;
         joy_down_ff         <= dac_pkg::JOY_DOWN_RESET;
         near_dist_ff        <= dac_pkg::NEAR_DIST_RESET;
         max_dist_ff         <= dac_pkg::MAX_DIST_RESET;
         servo_open_pulse_ff <= dac_pkg::SERVO_OPEN_RESET;
         servo_shut_pulse_ff <= dac_pkg::SERVO_SHUT_RESET;
         buzzer_duty_ff      <= dac_pkg::BUZZER_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dac_pkg::CSR_JOY_UP:      joy_up_ff           <= csr_data[dac_pkg::JOY_REG_BITS-1:0];
            dac_pkg::CSR_JOY_DOWN:    joy_down_ff         <= csr_data[dac_pkg::JOY_REG_BITS-1:0];
            dac_pkg::CSR_NEAR_DIST:   near_dist_ff        <= csr_data[dac_pkg::DIST_REG_BITS-1:0];
            dac_pkg::CSR_MAX_DIST:    max_dist_ff         <= csr_data[dac_pkg::DIST_REG_BITS-1:0];
            dac_pkg::CSR_SERVO_OPEN:  servo_open_pulse_ff <= csr_data[dac_pkg::PWM_BITS-1:0];
            dac_pkg::CSR_SERVO_SHUT:  servo_shut_pulse_ff <= csr_data[dac_pkg::PWM_BITS-1:0];
            dac_pkg::CSR_BUZZER_DUTY: buzzer_duty_ff      <= csr_data[dac_pkg::PWM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // State advances only on an accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= dac_pkg::MODE_INITIAL;
         alarm_hour_ff   <= '0;
         alarm_minute_ff <= '0;
         alarm_armed_ff  <= 1'b0;
         servo_open_ff   <= 1'b0;
         buzzer_on_ff    <= 1'b0;
         sensing_ff      <= 1'b0;
      end else if (req_fire) begin
         mode_ff         <= mode_in;
         alarm_hour_ff   <= alarm_hour_in;
         alarm_minute_ff <= alarm_minute_in;
         alarm_armed_ff  <= alarm_armed_in;
         servo_open_ff   <= servo_open_in;
         buzzer_on_ff    <= buzzer_on_in;
         sensing_ff      <= sensing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An accepted tick always leaves a result in the response register
   `DAC_ASSERT_NEXT(a_tick_gives_rsp, clock, reset, req_fire, rsp_valid_ff, "accepted tick produced no response")
   // Pill sensing is on exactly while the dispenser is open
   `DAC_ASSERT_SAME(a_sensing_tracks_servo, clock, reset, 1'b1, sensing_ff == servo_open_ff, "sensing and servo state disagree")
   // The stored alarm time never leaves the valid clock range
   `DAC_ASSERT_SAME(a_alarm_in_range, clock, reset, 1'b1, (alarm_hour_ff <= dac_pkg::HOUR_MAX) && (alarm_minute_ff <= dac_pkg::MINUTE_MAX), "alarm time out of range")

endmodule

`default_nettype wire
